// ===== hw/rtl/tsd_pkg.sv =====
// shared types, constants and helpers for the tar stream deframer
package tsd_pkg;

    localparam int BLOCK_BYTES_DEF = 512;
    localparam int OFS_MAGIC       = 257;
    localparam int MAGIC_LEN       = 5;
    localparam int OFS_TYPE        = 156;
    localparam int OFS_SIZE        = 124;
    localparam int SIZE_CHARS      = 12;
    localparam int SIZE_W          = 64;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_PAD    = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        KIND_HDR      = 4'd0,
        KIND_FILE     = 4'd1,
        KIND_PAD      = 4'd2,
        KIND_ENTRY    = 4'd3,
        KIND_END      = 4'd4,
        KIND_NOTUSTAR = 4'd5,
        KIND_TRUNC    = 4'd6,
        KIND_IGNORED  = 4'd7,
        KIND_ZERO     = 4'd8
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_word_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         out_byte;
        logic [SIZE_W-1:0]  file_size;
        logic [7:0]         entry_type;
        logic               is_regular;
        logic               last_of_file;
    } out_word_t;

    // header fields as seen including the byte of the current word
    typedef struct packed {
        logic               all_zero;
        logic               magic_ok;
        logic [SIZE_W-1:0]  size;
        logic [7:0]         type_byte;
    } hdr_info_t;

    // header update request from the sequencer
    typedef struct packed {
        logic en;
        logic clear;
    } hdr_ctl_t;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                3'd0:    c = 8'h75;
                3'd1:    c = 8'h73;
                3'd2:    c = 8'h74;
                3'd3:    c = 8'h61;
                3'd4:    c = 8'h72;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== hw/rtl/tar_stream_deframer_core.sv =====
// top level of the tar stream deframer: input register, parser and result register
//
// Takes a ustar archive one byte word per cycle unless stalled and returns exactly
// one result word per input word, telling whether the byte belongs to a header,
// file data or padding, and reporting each entry (size, type byte, regular flag)
// on the last byte of its header. Sustained rate is one word per cycle while
// res_stall does not hold the output: the word sits in an input register, one
// pass of header-field and phase logic runs, and the result lands in an output
// register that can be held by res_stall while the next word is already being
// taken. A stream_end word ends the archive (end or truncated); after that every
// word reads back as ignored until reset.
module tar_stream_deframer_core
    import tsd_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_word_t  byte_word,
    output logic      res_valid,
    input  logic      res_stall,
    output out_word_t res_word
);

    localparam int OFS_W = $clog2(BLOCK_BYTES);

    logic             in_valid_reg;
    in_word_t         in_word_reg;
    logic             out_valid_reg;
    out_word_t        out_word_reg;
    logic             advance;
    logic             take_in;

    hdr_info_t        info;
    hdr_ctl_t         hdr_ctl;
    logic [OFS_W-1:0] offset;
    out_word_t        result;

    assign advance    = in_valid_reg & (~out_valid_reg | ~res_stall);
    assign byte_stall = in_valid_reg & ~advance;
    assign take_in    = byte_valid & ~byte_stall;
    assign res_valid  = out_valid_reg;
    assign res_word   = out_word_reg;

    tsd_hdr #(
        .OFS_W (OFS_W)
    ) u_hdr (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (hdr_ctl),
        .cur_byte (in_word_reg.in_byte),
        .offset   (offset),
        .info     (info)
    );

    tsd_seq #(
        .OFS_W (OFS_W)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .word    (in_word_reg),
        .info    (info),
        .hdr_ctl (hdr_ctl),
        .offset  (offset),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= take_in | (in_valid_reg & ~advance);
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_word_reg <= byte_word;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

endmodule

// ===== hw/rtl/tsd_hdr.sv =====
// header block field capture: zero check, magic check, type byte and octal size
module tsd_hdr
    import tsd_pkg::*;
#(
    parameter int OFS_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  hdr_ctl_t         ctl,
    input  logic [7:0]       cur_byte,
    input  logic [OFS_W-1:0] offset,
    output hdr_info_t        info
);

    logic              all_zero_reg,   all_zero_next;
    logic              magic_reg,      magic_next;
    logic [SIZE_W-1:0] size_reg,       size_next;
    logic              size_done_reg,  size_done_next;
    logic [7:0]        type_reg,       type_next;

    logic              in_magic;
    logic              in_size;
    logic [2:0]        magic_idx;
    logic [OFS_W-1:0]  magic_rel;
    logic [SIZE_W-1:0] byte_ext;

    assign in_magic  = (offset >= OFS_W'(OFS_MAGIC)) &&
                       (offset <  OFS_W'(OFS_MAGIC + MAGIC_LEN));
    assign in_size   = (offset >= OFS_W'(OFS_SIZE)) &&
                       (offset <  OFS_W'(OFS_SIZE + SIZE_CHARS));
    assign magic_rel = offset - OFS_W'(OFS_MAGIC);
    assign magic_idx = magic_rel[2:0];
    assign byte_ext  = {{(SIZE_W - 8){cur_byte[7]}}, cur_byte};

    always_comb
    begin
        all_zero_next  = all_zero_reg & (cur_byte == CHAR_NUL);
        magic_next     = magic_reg;
        if (in_magic && (cur_byte != magic_char(magic_idx)))
        begin
            magic_next = 1'b0;
        end
        type_next      = (offset == OFS_W'(OFS_TYPE)) ? cur_byte : type_reg;
        size_next      = size_reg;
        size_done_next = size_done_reg;
        if (in_size && !size_done_reg)
        begin
            if ((cur_byte == CHAR_NUL) || (cur_byte == CHAR_SPACE))
            begin
                size_done_next = 1'b1;
            end
            else
            begin
                size_next = (size_reg << 3) + byte_ext - SIZE_W'(CHAR_ZERO);
            end
        end
    end

    assign info.all_zero  = all_zero_next;
    assign info.magic_ok  = magic_next;
    assign info.size      = size_next;
    assign info.type_byte = type_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_zero_reg  <= 1'b1;
            magic_reg     <= 1'b1;
            size_reg      <= '0;
            size_done_reg <= 1'b0;
            type_reg      <= '0;
        end
        else if (ctl.en)
        begin
            if (ctl.clear)
            begin
                all_zero_reg  <= 1'b1;
                magic_reg     <= 1'b1;
                size_reg      <= '0;
                size_done_reg <= 1'b0;
                type_reg      <= '0;
            end
            else
            begin
                all_zero_reg  <= all_zero_next;
                magic_reg     <= magic_next;
                size_reg      <= size_next;
                size_done_reg <= size_done_next;
                type_reg      <= type_next;
            end
        end
    end

endmodule

// ===== hw/rtl/tsd_seq.sv =====
// phase sequencer: block offset, zero block run, entry data count and result forming
module tsd_seq
    import tsd_pkg::*;
#(
    parameter int OFS_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  in_word_t         word,
    input  hdr_info_t        info,
    output hdr_ctl_t         hdr_ctl,
    output logic [OFS_W-1:0] offset,
    output out_word_t        result
);

    localparam logic [OFS_W-1:0] LAST_OFS = {OFS_W{1'b1}};

    phase_t            phase_reg, phase_next;
    logic [OFS_W-1:0]  off_reg,   off_next;
    logic              run_reg,   run_next;
    logic              reg_reg,   reg_next;
    logic [SIZE_W-1:0] rem_reg,   rem_next;

    logic [7:0]        cur_byte;
    logic              last_ofs;
    logic              type_regular;
    logic              hdr_en;

    assign cur_byte     = word.stream_end ? 8'h00 : word.in_byte;
    assign last_ofs     = (off_reg == LAST_OFS);
    assign type_regular = (info.type_byte == CHAR_NUL) || (info.type_byte == CHAR_ZERO);
    assign offset       = off_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (phase_reg != PH_DONE)
        begin
            if (word.stream_end)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (last_ofs)
                        begin
                            if (info.all_zero)
                            begin
                                if (run_reg)
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                            else if (!info.magic_ok)
                            begin
                                phase_next = PH_DONE;
                            end
                            else if (info.size != '0)
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (rem_reg == SIZE_W'(1))
                        begin
                            phase_next = last_ofs ? PH_HEADER : PH_PAD;
                        end
                    end
                    PH_PAD:
                    begin
                        if (last_ofs)
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // result word and datapath updates
    always_comb
    begin
        result              = '0;
        result.kind         = KIND_IGNORED;
        result.out_byte     = cur_byte;
        hdr_en              = 1'b0;
        hdr_ctl.clear       = 1'b0;
        off_next            = off_reg;
        run_next            = run_reg;
        reg_next            = reg_reg;
        rem_next            = rem_reg;
        if (phase_reg != PH_DONE)
        begin
            if (word.stream_end)
            begin
                result.kind = ((phase_reg == PH_HEADER) && (off_reg == '0)) ?
                              KIND_END : KIND_TRUNC;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        hdr_en      = 1'b1;
                        result.kind = KIND_HDR;
                        off_next    = off_reg + 1'b1;
                        if (last_ofs)
                        begin
                            hdr_ctl.clear = 1'b1;
                            if (info.all_zero)
                            begin
                                if (run_reg)
                                begin
                                    result.kind = KIND_END;
                                end
                                else
                                begin
                                    result.kind = KIND_ZERO;
                                    run_next    = 1'b1;
                                end
                            end
                            else
                            begin
                                run_next = 1'b0;
                                if (!info.magic_ok)
                                begin
                                    result.kind = KIND_NOTUSTAR;
                                end
                                else
                                begin
                                    result.kind       = KIND_ENTRY;
                                    result.file_size  = info.size;
                                    result.entry_type = info.type_byte;
                                    result.is_regular = type_regular;
                                    reg_next          = type_regular;
                                    rem_next          = info.size;
                                end
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        result.kind = reg_reg ? KIND_FILE : KIND_PAD;
                        off_next    = off_reg + 1'b1;
                        rem_next    = rem_reg - 1'b1;
                        if (rem_reg == SIZE_W'(1))
                        begin
                            result.last_of_file = reg_reg;
                        end
                    end
                    PH_PAD:
                    begin
                        result.kind = KIND_PAD;
                        off_next    = off_reg + 1'b1;
                    end
                    default:
                    begin
                        result.kind = KIND_IGNORED;
                    end
                endcase
            end
        end
        hdr_ctl.en = hdr_en & step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            off_reg   <= '0;
            run_reg   <= 1'b0;
            reg_reg   <= 1'b0;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            run_reg   <= run_next;
            reg_reg   <= reg_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

// ===== hw/rtl/tsd_checker.sv =====
// port-level checks for the tar stream deframer, bound to the top level
module tsd_checker
    import tsd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      byte_valid,
    input logic      byte_stall,
    input logic      res_valid,
    input logic      res_stall,
    input out_word_t res_word
);

    // held result word
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    // last flag only on file data
    a_last_file: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.last_of_file |-> res_word.kind == KIND_FILE)
        else $error("last flag outside file data");

    // entry fields only on entry ready
    a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.kind != KIND_ENTRY |->
            res_word.file_size == '0 && res_word.entry_type == '0 &&
            !res_word.is_regular)
        else $error("entry fields outside entry ready");

    // once a word is taken with no result pending, a result follows after the input and output registers
    a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && !res_valid |=> ##1 res_valid)
        else $error("accepted word produced no result");

endmodule

bind tar_stream_deframer_core tsd_checker u_tsd_checker (.*);
